// ===== hdl/hfx_pkg.sv =====
// Shared types and constants for the header field extractor.
// Depends on nothing; hfx_extract and the top level refer to it by scoped names.
`default_nettype none

package hfx_pkg;

	// Header storage and field table sizing.
	localparam int HEADER_BYTES = 64;
	localparam int MAX_FIELDS   = 6;
	localparam int NUM_DESC     = 6;
	localparam int ADDR_W       = $clog2(HEADER_BYTES);
	localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
	localparam int CMP_W        = (CNT_W > 7) ? CNT_W + 1 : 8;
	localparam int FIDX_W       = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 22;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FIELDS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DESC_0     = 3'd1;

	// Field types held in a descriptor.
	typedef enum logic [1:0] {
		TYPE_U8    = 2'd0,
		TYPE_U16   = 2'd1,
		TYPE_U32   = 2'd2,
		TYPE_ARRAY = 2'd3
	} ftype_t;

	// Packed descriptor, bit 0 is the endian flag.
	typedef struct packed {
		ftype_t      ftype;
		logic [5:0]  bit_len;
		logic [4:0]  bit_off;
		logic [1:0]  len_m1;
		logic [5:0]  start;
		logic        big;
	} desc_t;

	typedef desc_t [NUM_DESC-1:0] desc_tbl_t;

	// One input item: a packet byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} in_item_t;

	// One result item: an extracted field.
	typedef struct packed {
		logic [2:0]  field_index;
		logic [31:0] field_value;
		logic        is_offset;
		logic        status;
		logic        last_field;
	} out_item_t;

	// Packet close command from the byte capture side to the extractor.
	typedef struct packed {
		logic             go;
		logic [CNT_W-1:0] received;
		logic [FIDX_W-1:0] nfields;
	} cmd_t;

	// Extractor sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_FETCH,
		S_ACC,
		S_CALC
	} ext_state_t;

endpackage

`default_nettype wire

// ===== hdl/hfx_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module hfx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/hfx_extract.sv =====
// Field extraction sequencer: walks the descriptor table after a packet closes,
// reads header bytes from the store one at a time and holds each result item.
// Depends on hfx_pkg.
`default_nettype none

module hfx_extract (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hfx_pkg::cmd_t                 cmd,
	input  wire hfx_pkg::desc_tbl_t            descs,
	output logic                               idle,
	output logic      [hfx_pkg::ADDR_W-1:0]    raddr,
	input  wire logic [7:0]                    rdata,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output hfx_pkg::out_item_t                 res_item
);

	hfx_pkg::ext_state_t state_q, state_d;
	logic [hfx_pkg::FIDX_W-1:0] fidx_q, fidx_d;
	logic [1:0]                 k_q, k_d;
	logic                       res_valid_q, res_valid_d;
	logic [hfx_pkg::FIDX_W-1:0] nfld_q;
	logic [hfx_pkg::CNT_W-1:0]  rcv_q;
	logic [31:0]                word_q, word_d;
	hfx_pkg::out_item_t         res_q, res_d;

	hfx_pkg::desc_t             d;
	logic [2:0]                 len;
	logic [hfx_pkg::CMP_W-1:0]  end_sum;
	logic [hfx_pkg::CMP_W-1:0]  rcv_ext;
	logic [hfx_pkg::CMP_W-1:0]  start_ext;
	logic                       is_arr;
	logic                       int_err;
	logic                       arr_err;
	logic [31:0]                shifted;
	logic [31:0]                mask;
	logic [31:0]                val;
	logic                       is_last;
	logic                       slot_free;
	logic                       load;
	logic [6:0]                 byte_addr;

	// Decode the current descriptor and check it against the received count.
	always_comb begin
		d         = descs[fidx_q];
		len       = {1'b0, d.len_m1} + 3'd1;
		start_ext = hfx_pkg::CMP_W'(d.start);
		end_sum   = start_ext + hfx_pkg::CMP_W'(len);
		rcv_ext   = hfx_pkg::CMP_W'(rcv_q);
		is_arr    = (d.ftype == hfx_pkg::TYPE_ARRAY);
		int_err   = (end_sum > rcv_ext);
		arr_err   = (start_ext > rcv_ext);
		is_last   = ((fidx_q + 3'd1) == nfld_q);
		byte_addr = {1'b0, d.start} + {5'd0, k_q};
	end

	// Shift, mask and truncate the assembled word.
	always_comb begin
		shifted = word_q >> d.bit_off;
		if (d.bit_len >= 6'd32) begin
			mask = 32'hFFFF_FFFF;
		end else begin
			mask = ~(32'hFFFF_FFFF << d.bit_len);
		end
		val = shifted & mask;
		case (d.ftype)
			hfx_pkg::TYPE_U8:  val = val & 32'h0000_00FF;
			hfx_pkg::TYPE_U16: val = val & 32'h0000_FFFF;
			default:           val = val;
		endcase
	end

	assign slot_free = !res_valid_q || res_ready;

	// Next state, byte assembly and result loading.
	always_comb begin
		state_d     = state_q;
		fidx_d      = fidx_q;
		k_d         = k_q;
		word_d      = word_q;
		res_d       = res_q;
		res_valid_d = res_valid_q && !res_ready;
		load        = 1'b0;
		raddr       = hfx_pkg::ADDR_W'(byte_addr);
		case (state_q)
			hfx_pkg::S_IDLE: begin
				fidx_d = '0;
				if (cmd.go && (cmd.nfields != '0)) begin
					state_d = hfx_pkg::S_SETUP;
				end
			end
			hfx_pkg::S_SETUP: begin
				k_d    = 2'd0;
				word_d = '0;
				if (is_arr || int_err) begin
					state_d = hfx_pkg::S_CALC;
				end else begin
					state_d = hfx_pkg::S_FETCH;
				end
			end
			hfx_pkg::S_FETCH: begin
				// The read address is issued here; data returns next cycle.
				state_d = hfx_pkg::S_ACC;
			end
			hfx_pkg::S_ACC: begin
				if (d.big) begin
					word_d = {word_q[23:0], rdata};
				end else begin
					word_d[8*k_q +: 8] = rdata;
				end
				k_d = k_q + 2'd1;
				if (k_q == d.len_m1) begin
					state_d = hfx_pkg::S_CALC;
				end else begin
					state_d = hfx_pkg::S_FETCH;
				end
			end
			hfx_pkg::S_CALC: begin
				if (slot_free) begin
					load                 = 1'b1;
					res_valid_d          = 1'b1;
					res_d.field_index    = fidx_q;
					res_d.is_offset      = is_arr;
					res_d.last_field     = is_last;
					if (is_arr) begin
						res_d.field_value = 32'(d.start);
						res_d.status      = arr_err;
					end else begin
						res_d.field_value = int_err ? 32'd0 : val;
						res_d.status      = int_err;
					end
					if (is_last) begin
						state_d = hfx_pkg::S_IDLE;
					end else begin
						fidx_d  = fidx_q + 3'd1;
						state_d = hfx_pkg::S_SETUP;
					end
				end
			end
			default: begin
				state_d = hfx_pkg::S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hfx_pkg::S_IDLE;
			fidx_q      <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fidx_q      <= fidx_d;
			k_q         <= k_d;
			res_valid_q <= res_valid_d;
		end
	end

	// Payload registers: packet parameters, assembled word and result.
	always_ff @(posedge clk) begin
		if (state_q == hfx_pkg::S_IDLE && cmd.go) begin
			nfld_q <= cmd.nfields;
			rcv_q  <= cmd.received;
		end
		word_q <= word_d;
		res_q  <= res_d;
	end

	assign idle      = (state_q == hfx_pkg::S_IDLE);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

`ifndef SYNTHESIS
	// A byte is only accumulated in the cycle after its read was issued.
	a_acc_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfx_pkg::S_ACC |-> $past(state_q) == hfx_pkg::S_FETCH)
		else $error("byte accumulated without a preceding read");

	// The field counter never walks past the active field count.
	a_fidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != hfx_pkg::S_IDLE |-> fidx_q < nfld_q)
		else $error("field counter beyond active field count");

	// The final result of a packet returns the sequencer to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && is_last |=> state_q == hfx_pkg::S_IDLE)
		else $error("sequencer busy after last field");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!res_valid_q || res_ready))
		else $error("result register overwritten");

	// The byte counter stays within the descriptor's length.
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hfx_pkg::S_ACC |-> k_q <= d.len_m1)
		else $error("byte counter beyond field length");
`endif

endmodule

`default_nettype wire

// ===== hdl/table_driven_header_field_extractor.sv =====
// Header field extractor. Bytes are taken one per cycle while no fields are
// being extracted. After the end-of-packet byte, each field passes a setup state, a
// fetch and an accumulate state per header byte read from the store, and a load state
// that waits while the previous result is unaccepted; array and out-of-range fields
// skip the fetch and accumulate states. Bytes are refused until the last result is
// loaded. Reset clears the byte count, sequencer and config registers, not the store.
`default_nettype none

module table_driven_header_field_extractor (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [hfx_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [hfx_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              byte_valid,
	output logic                                   byte_ready,
	input  wire hfx_pkg::in_item_t                 byte_item,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output hfx_pkg::out_item_t                     res_item
);

	logic [2:0]                 num_fields_q;
	hfx_pkg::desc_tbl_t         descs_q;
	logic [hfx_pkg::CNT_W-1:0]  byte_count_q;
	logic [hfx_pkg::CNT_W-1:0]  count_inc;
	logic [hfx_pkg::CFG_IDX_W-1:0] desc_sel;
	logic                       accept;
	logic                       store_we;
	logic                       ext_idle;
	logic [hfx_pkg::ADDR_W-1:0] raddr;
	logic [7:0]                 rdata;
	hfx_pkg::cmd_t              cmd;

	// Configuration registers.
	assign desc_sel = cfg_idx - hfx_pkg::REG_DESC_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_fields_q <= '0;
			descs_q      <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == hfx_pkg::REG_NUM_FIELDS) begin
				num_fields_q <= cfg_data[2:0];
			end else if (cfg_idx <= hfx_pkg::CFG_IDX_W'(hfx_pkg::NUM_DESC)) begin
				descs_q[desc_sel] <= hfx_pkg::desc_t'(cfg_data);
			end
		end
	end

	// Byte capture: store while room remains, close the packet on its last byte.
	assign byte_ready = ext_idle;
	assign accept     = byte_valid && byte_ready;
	assign store_we   = accept && (byte_count_q < hfx_pkg::CNT_W'(hfx_pkg::HEADER_BYTES));
	assign count_inc  = store_we ? byte_count_q + hfx_pkg::CNT_W'(1) : byte_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
		end else if (accept) begin
			if (byte_item.end_of_packet) begin
				byte_count_q <= '0;
			end else begin
				byte_count_q <= count_inc;
			end
		end
	end

	// Command to the extractor, with the field count clamped to the table size.
	always_comb begin
		cmd.go       = accept && byte_item.end_of_packet;
		cmd.received = count_inc;
		if (num_fields_q > hfx_pkg::FIDX_W'(hfx_pkg::MAX_FIELDS)) begin
			cmd.nfields = hfx_pkg::FIDX_W'(hfx_pkg::MAX_FIELDS);
		end else begin
			cmd.nfields = num_fields_q;
		end
	end

	hfx_ram #(
		.WIDTH (8),
		.DEPTH (hfx_pkg::HEADER_BYTES)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (byte_count_q[hfx_pkg::ADDR_W-1:0]),
		.wdata (byte_item.data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	hfx_extract u_extract (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.descs     (descs_q),
		.idle      (ext_idle),
		.raddr     (raddr),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire
